// ===== rtl/core/fltw_pkg.sv =====
// Shared types, codes and helpers for the four-level page-table walker.
package fltw_pkg;

	localparam int unsigned TABLE_FRAMES_DEF = 8;
	localparam int unsigned WORDS_PER_FRAME  = 512;
	localparam int unsigned PA_W             = 52;
	localparam int unsigned VA_W             = 48;
	localparam int unsigned WORD_W           = 64;
	localparam int unsigned WIDX_W           = 12;
	localparam int unsigned IDX_W            = 9;
	localparam int unsigned FAULT_W          = 3;
	localparam int unsigned BIT_PRESENT      = 0;
	localparam int unsigned BIT_HUGE         = 7;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_XLATE = 2'd1,
		CMD_UNMAP = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_ROOT = 1'b0,
		CFG_BASE = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_RESP
	} state_t;

	localparam logic [FAULT_W-1:0] FAULT_NONE = 3'd0;
	localparam logic [FAULT_W-1:0] FAULT_PML4 = 3'd1;

	typedef struct packed {
		cmd_t                cmd;
		logic [VA_W-1:0]     virt_addr;
		logic [WIDX_W-1:0]   word_index;
		logic [WORD_W-1:0]   word_data;
	} req_t;

	typedef struct packed {
		logic [PA_W-1:0]     phys_addr;
		logic                ok;
		logic                huge_page;
		logic [FAULT_W-1:0]  fault_level;
	} rsp_t;

	// table index of a virtual address at a given level (0 = PML4)
	function automatic logic [IDX_W-1:0] va_idx(input logic [VA_W-1:0] va,
			input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

// ===== rtl/core/fltw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fltw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/four_level_page_table_walker_top.sv =====
// Four-level page-table walker: table store, walk sequencer and response register.
//
//  channel | signals                               | dir | notes
//  req     | req_valid, req_stall, req (req_t)     | in  | write word / translate / unmap
//  rsp     | rsp_valid, rsp_stall, rsp (rsp_t)     | out | one response per request
//  cfg     | cfg_valid, cfg_ready, cfg_index, data | in  | root and store base registers
//
// Write word and unused commands finish when accepted. Translate and unmap issue the
// PML4 read and then read one table level at a time, as set by the
// single read port of the table store.
// The store has no reset; root and base registers clear to zero on arst_n.
// rsp_stall holds a finished result in a spare register; req_stall is high while a walk
// runs or a result waits.
module four_level_page_table_walker_top #(
	parameter int unsigned TABLE_FRAMES = fltw_pkg::TABLE_FRAMES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  fltw_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output fltw_pkg::rsp_t             rsp,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  fltw_pkg::cfg_idx_t         cfg_index,
	input  logic [fltw_pkg::PA_W-1:0]  cfg_data
);

	localparam int unsigned DEPTH = TABLE_FRAMES * fltw_pkg::WORDS_PER_FRAME;
	localparam int unsigned FBW   = $clog2(TABLE_FRAMES);
	localparam int unsigned AW    = FBW + fltw_pkg::IDX_W;
	localparam int unsigned PA_W  = fltw_pkg::PA_W;

	fltw_pkg::state_t state_q, state_d;

	logic [PA_W-1:0]          root_q;
	logic [PA_W-1:0]          base_q;
	logic [fltw_pkg::VA_W-1:0] va_q;
	fltw_pkg::cmd_t           cmd_q;
	logic [1:0]               lvl_q;
	logic [AW-1:0]            loc_q;
	fltw_pkg::rsp_t           res_q;
	fltw_pkg::rsp_t           rsp_q;
	logic                     rsp_valid_q;

	logic                          accept;
	logic                          slot_free;
	logic                          done;
	logic                          start;
	logic                          advance;
	fltw_pkg::rsp_t                res;
	logic                          rsp_load;
	fltw_pkg::rsp_t                rsp_d;
	logic                          wr_en;
	logic [AW-1:0]                 wr_addr;
	logic [fltw_pkg::WORD_W-1:0]   wr_data;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	logic [fltw_pkg::WORD_W-1:0]   rd_data;
	logic [AW:0]                   fc_root;
	logic [AW:0]                   fc_next;
	logic [1:0]                    lvl_nx;

	// {in store, word address} of a table entry; bits 11..0 of the table address ignored
	function automatic logic [AW:0] frame_loc(input logic [PA_W-1:0] tbl,
			input logic [PA_W-1:0] base, input logic [fltw_pkg::IDX_W-1:0] idx);
		logic [PA_W-1:0] t;
		logic [PA_W-1:0] diff;
		logic            in_store;
		t        = {tbl[PA_W-1:12], 12'h000};
		diff     = t - base;
		in_store = (t >= base) && (diff[11:0] == 12'h000)
			&& (diff[PA_W-1:12] < (PA_W-12)'(TABLE_FRAMES));
		return {in_store, diff[12 +: FBW], idx};
	endfunction

	fltw_ram #(
		.WIDTH (fltw_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign accept    = req_valid && (state_q == fltw_pkg::ST_IDLE);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign lvl_nx    = lvl_q + 2'd1;
	assign fc_root   = frame_loc(root_q, base_q, fltw_pkg::va_idx(req.virt_addr, 2'd0));
	assign fc_next   = frame_loc(rd_data[PA_W-1:0], base_q, fltw_pkg::va_idx(va_q, lvl_nx));

	// walk step: memory accesses and the result when the request finishes
	always_comb begin
		done    = 1'b0;
		start   = 1'b0;
		advance = 1'b0;
		res     = '0;
		wr_en   = 1'b0;
		wr_addr = AW'(req.word_index);
		wr_data = req.word_data;
		rd_en   = 1'b0;
		rd_addr = fc_root[AW-1:0];
		unique case (state_q)
			fltw_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.cmd) inside
						fltw_pkg::CMD_WRITE: begin
							done   = 1'b1;
							wr_en  = 32'(req.word_index) < 32'(DEPTH);
							res.ok = wr_en;
						end
						fltw_pkg::CMD_XLATE, fltw_pkg::CMD_UNMAP: begin
							if (fc_root[AW]) begin
								start = 1'b1;
								rd_en = 1'b1;
							end else begin
								done            = 1'b1;
								res.fault_level = fltw_pkg::FAULT_PML4;
							end
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			fltw_pkg::ST_WALK: begin
				wr_addr = loc_q;
				wr_data = '0;
				rd_addr = fc_next[AW-1:0];
				if (lvl_q == 2'd3 && cmd_q == fltw_pkg::CMD_UNMAP) begin
					done   = 1'b1;
					wr_en  = 1'b1;
					res.ok = 1'b1;
				end else if (!rd_data[fltw_pkg::BIT_PRESENT]) begin
					done            = 1'b1;
					res.fault_level = {1'b0, lvl_q} + 3'd1;
				end else if (lvl_q == 2'd2 && rd_data[fltw_pkg::BIT_HUGE]) begin
					done          = 1'b1;
					res.ok        = 1'b1;
					res.huge_page = 1'b1;
					if (cmd_q == fltw_pkg::CMD_UNMAP) begin
						wr_en = 1'b1;
					end else begin
						res.phys_addr = {rd_data[PA_W-1:21], va_q[20:0]};
					end
				end else if (lvl_q == 2'd3) begin
					done          = 1'b1;
					res.ok        = 1'b1;
					res.phys_addr = {rd_data[PA_W-1:12], va_q[11:0]};
				end else if (!fc_next[AW]) begin
					done            = 1'b1;
					res.fault_level = {1'b0, lvl_q} + 3'd2;
				end else begin
					advance = 1'b1;
					rd_en   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fltw_pkg::ST_IDLE: begin
				if (start) begin
					state_d = fltw_pkg::ST_WALK;
				end else if (done && !slot_free) begin
					state_d = fltw_pkg::ST_RESP;
				end
			end
			fltw_pkg::ST_WALK: begin
				if (done) begin
					state_d = slot_free ? fltw_pkg::ST_IDLE : fltw_pkg::ST_RESP;
				end
			end
			fltw_pkg::ST_RESP: begin
				if (slot_free) begin
					state_d = fltw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fltw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = state_q != fltw_pkg::ST_IDLE;
		rsp_load  = 1'b0;
		rsp_d     = res;
		unique case (state_q)
			fltw_pkg::ST_IDLE, fltw_pkg::ST_WALK: begin
				rsp_load = done && slot_free;
			end
			fltw_pkg::ST_RESP: begin
				rsp_load = slot_free;
				rsp_d    = res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fltw_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			root_q      <= '0;
			base_q      <= '0;
		end else begin
			state_q <= state_d;
			if (slot_free) begin
				rsp_valid_q <= rsp_load;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					fltw_pkg::CFG_ROOT: root_q <= cfg_data;
					fltw_pkg::CFG_BASE: base_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			va_q  <= req.virt_addr;
			cmd_q <= req.cmd;
			lvl_q <= 2'd0;
			loc_q <= fc_root[AW-1:0];
		end else if (advance) begin
			lvl_q <= lvl_nx;
			loc_q <= fc_next[AW-1:0];
		end
		if (done) begin
			res_q <= res;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store read and write in the same cycle");

	a_walk_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fltw_pkg::ST_WALK && wr_en) |-> (wr_data == '0 && res.ok))
		else $error("walk wrote a non-zero entry");

	a_ok_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.ok && rsp_q.fault_level != fltw_pkg::FAULT_NONE))
		else $error("response both ok and faulted");

	a_huge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.ok || (!rsp_q.huge_page && rsp_q.phys_addr == '0)))
		else $error("failed response carries a mapping");

	a_resp_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fltw_pkg::ST_RESP) |-> rsp_valid_q)
		else $error("result parked with empty output register");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the four-level page-table walker: directed and random walks.
`timescale 1ns / 100ps

module testbench;
	import fltw_pkg::*;

	localparam int unsigned FRAMES    = TABLE_FRAMES_DEF;
	localparam int unsigned STORE_LEN = FRAMES * WORDS_PER_FRAME;
	localparam cmd_t        CMD_SPARE = cmd_t'(2'd3);
	localparam logic [63:0] TBL_FIELD = 64'h000F_FFFF_FFFF_F000;

	class walk_scoreboard;
		logic [WORD_W-1:0] words [STORE_LEN];
		bit                filled [STORE_LEN];
		logic [PA_W-1:0]   root;
		logic [PA_W-1:0]   base;
		rsp_t              due [$];
		int errors, accepted, n_write, n_xlate, n_unmap, n_spare, n_huge, n_small;
		int faults [5];

		function new();
			root = '0;
			base = '0;
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void set_register(cfg_idx_t idx, logic [PA_W-1:0] val);
			if (idx == CFG_ROOT) begin
				root = val;
			end else begin
				base = val;
			end
		endfunction

		function bit table_slot(input logic [63:0] tbl, output int unsigned off);
			logic [63:0] t, b, d;
			off = 0;
			t = tbl & TBL_FIELD;
			b = {12'b0, base};
			if (t < b)
				return 1'b0;
			d = t - b;
			if ((d >> 12) >= 64'(FRAMES) || d[11:0] != 12'h000)
				return 1'b0;
			off = int'(d >> 12) * WORDS_PER_FRAME;
			return 1'b1;
		endfunction

		function int unsigned level_index(logic [VA_W-1:0] va, int lvl);
			return int'((va >> (39 - 9 * lvl)) & 48'h1FF);
		endfunction

		function rsp_t translate_walk(req_t r);
			rsp_t o;
			logic [63:0] tbl, ent;
			int unsigned off, loc;
			int lvl;
			o = '0;
			case (r.cmd)
				CMD_WRITE: begin
					n_write++;
					if (r.word_index < STORE_LEN) begin
						words[r.word_index] = r.word_data;
						filled[r.word_index] = 1'b1;
						o.ok = 1'b1;
					end
				end
				CMD_XLATE, CMD_UNMAP: begin
					if (r.cmd == CMD_XLATE) n_xlate++;
					else n_unmap++;
					tbl = {12'b0, root};
					for (lvl = 0; lvl < 4; lvl++) begin
						if (!table_slot(tbl, off)) begin
							o.fault_level = FAULT_W'(lvl + 1);
							break;
						end
						loc = off + level_index(r.virt_addr, lvl);
						ent = words[loc];
						if (lvl == 3 && r.cmd == CMD_UNMAP) begin
							words[loc] = '0;
							o.ok = 1'b1;
							break;
						end
						if (!ent[BIT_PRESENT]) begin
							o.fault_level = FAULT_W'(lvl + 1);
							break;
						end
						if (lvl == 2 && ent[BIT_HUGE]) begin
							o.huge_page = 1'b1;
							o.ok = 1'b1;
							if (r.cmd == CMD_UNMAP) begin
								words[loc] = '0;
							end else begin
								o.phys_addr = {ent[51:21], r.virt_addr[20:0]};
								n_huge++;
							end
							break;
						end
						if (lvl == 3) begin
							o.phys_addr = {ent[51:12], r.virt_addr[11:0]};
							o.ok = 1'b1;
							n_small++;
							break;
						end
						tbl = ent;
					end
					faults[o.fault_level]++;
				end
				default: n_spare++;
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			accepted++;
			due.push_back(translate_walk(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (due.size() == 0) begin
				$display("%0t: response with nothing outstanding: %h", $time, got);
				errors++;
				return;
			end
			want = due.pop_front();
			if (got.phys_addr !== want.phys_addr) begin
				$display("%0t: phys_addr expected %h actual %h", $time, want.phys_addr,
					got.phys_addr);
				errors++;
			end
			if (got.ok !== want.ok) begin
				$display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
				errors++;
			end
			if (got.huge_page !== want.huge_page) begin
				$display("%0t: huge_page expected %b actual %b", $time, want.huge_page,
					got.huge_page);
				errors++;
			end
			if (got.fault_level !== want.fault_level) begin
				$display("%0t: fault_level expected %0d actual %0d", $time, want.fault_level,
					got.fault_level);
				errors++;
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req       = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_ROOT;
	logic [PA_W-1:0]     cfg_data  = '0;

	walk_scoreboard  sb = new();
	int              settings_used = 1;
	logic [VA_W-1:0] va_pool [$];

	four_level_page_table_walker_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic bit idling_allowed();
		return !(sb.accepted >= 700 && sb.accepted < 850);
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic req_t mk_write(logic [WIDX_W-1:0] idx, logic [WORD_W-1:0] data);
		req_t r;
		logic [63:0] w;
		w = random_word();
		r.cmd = CMD_WRITE;
		r.virt_addr = w[VA_W-1:0];
		r.word_index = idx;
		r.word_data = data;
		return r;
	endfunction

	function automatic req_t mk_walk(cmd_t c, logic [VA_W-1:0] va);
		req_t r;
		r.cmd = c;
		r.virt_addr = va;
		r.word_index = WIDX_W'($urandom);
		r.word_data = random_word();
		return r;
	endfunction

	// table entry for a level: mostly a present pointer into the store
	function automatic logic [63:0] fresh_entry(int lvl);
		logic [63:0] e;
		logic [PA_W-1:0] a;
		int r;
		e = random_word();
		r = $urandom_range(0, 99);
		if (lvl == 3) begin
			e[BIT_PRESENT] = (r >= 10);
			return e;
		end
		if (r < 8) begin
			e[BIT_PRESENT] = 1'b0;
			return e;
		end
		e[BIT_PRESENT] = 1'b1;
		if (r < 14) begin
			case ($urandom_range(0, 2))
				0: a = sb.base + PA_W'(FRAMES * 4096);
				1: a = sb.base - PA_W'(4096);
				default: a = e[PA_W-1:0];
			endcase
			e[51:12] = a[51:12];
			return e;
		end
		if (lvl == 2 && r < 40) begin
			e[BIT_HUGE] = 1'b1;
			return e;
		end
		a = sb.base + PA_W'($urandom_range(0, FRAMES - 1)) * PA_W'(4096);
		e[51:12] = a[51:12];
		if (lvl == 2)
			e[BIT_HUGE] = 1'b0;
		return e;
	endfunction

	function automatic logic [VA_W-1:0] pick_va();
		logic [63:0] w;
		logic [VA_W-1:0] va;
		w = random_word();
		if (va_pool.size() == 0 || $urandom_range(0, 99) < 35) begin
			va = w[VA_W-1:0];
		end else begin
			va = va_pool[$urandom_range(0, va_pool.size() - 1)];
			case ($urandom_range(0, 3))
				0: va[11:0] = w[11:0];
				1: va[20:0] = w[20:0];
				2: va[20:12] = w[20:12];
				default: va[38:30] = w[38:30];
			endcase
		end
		va_pool.push_back(va);
		if (va_pool.size() > 48)
			void'(va_pool.pop_front());
		return va;
	endfunction

	task automatic send(req_t r);
		while (idling_allowed() && $urandom_range(0, 99) < 21) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic set_mapping(logic [PA_W-1:0] root_addr, logic [PA_W-1:0] base_addr);
		settings_used++;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ROOT;
		cfg_data <= root_addr;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(CFG_ROOT, root_addr);
		cfg_index <= CFG_BASE;
		cfg_data <= base_addr;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(CFG_BASE, base_addr);
		cfg_valid <= 1'b0;
	endtask

	// fill in any table word the walk would touch before it has been written
	task automatic issue_walk(cmd_t c, logic [VA_W-1:0] va);
		logic [63:0] planned [int unsigned];
		logic [63:0] tbl, ent;
		int unsigned off, loc;
		int lvl;
		req_t writes [$];
		tbl = {12'b0, sb.root};
		for (lvl = 0; lvl < 4; lvl++) begin
			if (!sb.table_slot(tbl, off))
				break;
			loc = off + sb.level_index(va, lvl);
			if (planned.exists(loc)) begin
				ent = planned[loc];
			end else if (sb.filled[loc]) begin
				ent = sb.words[loc];
			end else begin
				ent = fresh_entry(lvl);
				planned[loc] = ent;
				writes.push_back(mk_write(WIDX_W'(loc), ent));
			end
			if (lvl == 3 || !ent[BIT_PRESENT] || (lvl == 2 && ent[BIT_HUGE]))
				break;
			tbl = ent;
		end
		foreach (writes[i])
			send(writes[i]);
		send(mk_walk(c, va));
	endtask

	task automatic random_phase(int upto);
		int r;
		while (sb.accepted < upto) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				issue_walk(CMD_XLATE, pick_va());
			else if (r < 75)
				issue_walk(CMD_UNMAP, pick_va());
			else if (r < 93)
				send(mk_write(WIDX_W'($urandom), random_word()));
			else if (r < 98)
				send(mk_walk(CMD_SPARE, pick_va()));
			else
				drain();
		end
	endtask

	initial begin
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if (!held && sb.accepted >= 400) begin
				held = 1'b1;
				hold = 150;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= idling_allowed() && ($urandom_range(0, 99) < 21);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Run timed out with %0d responses outstanding", sb.pending());
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int guard;
		logic [63:0] w;
		logic [PA_W-1:0] b;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small hand-built hierarchy at root 0, base 0
		send(mk_write(12'd0, 64'hFFF0_0000_0000_1001));
		send(mk_write(12'd511, 64'h0000_0000_0000_7001));
		send(mk_write(12'd512, 64'h0000_0000_0000_2081));
		send(mk_write(12'd1024, 64'h0000_0000_0000_3001));
		send(mk_write(12'd1025, 64'h000F_FFFF_FFE0_0081));
		send(mk_write(12'd1536, 64'h000F_FFFF_FFFF_F001));
		send(mk_write(12'd1537, 64'h0));
		send(mk_walk(CMD_XLATE, 48'h0000_0000_0ABC));
		send(mk_walk(CMD_XLATE, 48'h0000_003F_FFFF));
		send(mk_walk(CMD_XLATE, 48'h0000_0000_1000));
		send(mk_write(12'd1, 64'hFFFF_FFFF_FFFF_FFFE));
		send(mk_walk(CMD_XLATE, 48'h0080_0000_0000));
		send(mk_write(12'd513, 64'h0));
		send(mk_walk(CMD_XLATE, 48'h0000_4000_0000));
		send(mk_write(12'd1026, 64'h0000_0000_0000_3000));
		send(mk_walk(CMD_XLATE, 48'h0000_0040_0000));
		send(mk_write(12'd514, 64'h0000_0000_0000_8001));
		send(mk_walk(CMD_XLATE, 48'h0000_8000_0000));
		send(mk_walk(CMD_UNMAP, 48'h0000_0000_0000));
		send(mk_walk(CMD_XLATE, 48'h0000_0000_0000));
		send(mk_walk(CMD_UNMAP, 48'h0000_0020_0000));
		send(mk_walk(CMD_XLATE, 48'h0000_0020_0000));
		send(mk_walk(CMD_UNMAP, 48'h0000_0000_1000));
		send(mk_walk(CMD_SPARE, 48'h0000_0000_0000));
		send(mk_write(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF));
		send(mk_walk(CMD_XLATE, 48'hFFFF_FFFF_FFFF));

		random_phase(260);

		drain();
		w = random_word();
		b = {w[51:12], 12'h000};
		set_mapping({b[51:12] + 40'($urandom_range(0, FRAMES - 1)), w[11:0]}, b);
		random_phase(560);

		drain();
		set_mapping(52'h0_0000_0000_7ABC, 52'h0);
		random_phase(800);

		// store at the very top of the address space
		drain();
		set_mapping(52'hF_FFFF_FFFF_BFFF, 52'hF_FFFF_FFFF_8000);
		random_phase(1000);

		drain();
		set_mapping({PA_W{1'b1}}, {PA_W{1'b1}});
		random_phase(1020);

		// unaligned base leaves no usable frame
		drain();
		w = random_word();
		b = {w[51:12], 12'($urandom_range(1, 4095))};
		set_mapping({b[51:12] + 40'd1, 12'h000}, b);
		random_phase(1040);

		drain();
		set_mapping(52'h0_0000_000F_F000, 52'h0_0000_0010_0000);
		random_phase(1060);

		drain();
		set_mapping(52'h0_0000_0010_8000, 52'h0_0000_0010_0000);
		random_phase(1080);

		drain();
		w = random_word();
		b = {w[51:12], 12'h000};
		set_mapping({b[51:12] + 40'($urandom_range(0, FRAMES - 1)), 12'h000}, b);
		random_phase(1350);

		req_valid <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d responses never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("Covered %0d requests: %0d table writes, %0d translations, %0d unmaps, %0d unused codes, %0d register settings",
			sb.accepted, sb.n_write, sb.n_xlate, sb.n_unmap, sb.n_spare, settings_used);
		$display("Walks ending on 4 KB pages %0d, on 2 MB pages %0d; faults PML4/PDPT/PD/PT %0d/%0d/%0d/%0d",
			sb.n_small, sb.n_huge, sb.faults[1], sb.faults[2], sb.faults[3], sb.faults[4]);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
